FILE: design/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg: shared types and constants of the triangle unit normal block
// Holds the control word that travels next to the arithmetic pipeline.
// ----------------------------------------------------------------------------
package tun_pkg;

  // Number of normal components handled side by side
  localparam int unsigned LANES = 3;

  // Fixed width of one normal component on the result word (Q2.14)
  localparam int unsigned OUT_W = 16;

  // Control word that rides along the pipeline next to the data
  typedef struct packed {
    logic             valid;
    logic             degen;
    logic [LANES-1:0] neg;
  } ctl_t;

endpackage

FILE: design/tun_in_if.sv
// ----------------------------------------------------------------------------
// tun_in_if: triangle input channel
// Valid/ready channel carrying the three vertices of one triangle.
// ----------------------------------------------------------------------------
interface tun_in_if #(
  parameter int unsigned COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] ax;
  logic signed [COORD_WIDTH-1:0] ay;
  logic signed [COORD_WIDTH-1:0] az;
  logic signed [COORD_WIDTH-1:0] bx;
  logic signed [COORD_WIDTH-1:0] by_coord;
  logic signed [COORD_WIDTH-1:0] bz;
  logic signed [COORD_WIDTH-1:0] cx;
  logic signed [COORD_WIDTH-1:0] cy;
  logic signed [COORD_WIDTH-1:0] cz;

  modport source (
    output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
    input  ready
  );
  modport sink (
    input  valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
    output ready
  );
endinterface

FILE: design/tun_out_if.sv
// ----------------------------------------------------------------------------
// tun_out_if: unit normal output channel
// Valid/ready channel carrying one Q2.14 unit normal and the degenerate flag.
// ----------------------------------------------------------------------------
interface tun_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [tun_pkg::OUT_W-1:0] nx;
  logic signed [tun_pkg::OUT_W-1:0] ny;
  logic signed [tun_pkg::OUT_W-1:0] nz;
  logic                             degenerate;

  modport source (
    output valid, nx, ny, nz, degenerate,
    input  ready
  );
  modport sink (
    input  valid, nx, ny, nz, degenerate,
    output ready
  );
endinterface

FILE: design/tun_front.sv
// ----------------------------------------------------------------------------
// tun_front: edges, cross product, squares and squared length
// Six register stages: edges, products, cross terms, partial squares,
// squares, sum of squares with zero detect.
// ----------------------------------------------------------------------------
module tun_front #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned SW          = 74
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [COORD_WIDTH-1:0] a_i [tun_pkg::LANES],
  input  logic signed [COORD_WIDTH-1:0] b_i [tun_pkg::LANES],
  input  logic signed [COORD_WIDTH-1:0] c_i [tun_pkg::LANES],
  output tun_pkg::ctl_t                 ctl_o,
  output logic [SW-1:0]                 sq_o [tun_pkg::LANES],
  output logic [SW-1:0]                 s_o
);

  localparam int unsigned EW  = COORD_WIDTH + 1;  // edge
  localparam int unsigned PW  = 2 * EW;           // product, cross magnitude
  localparam int unsigned CNW = PW + 1;           // signed cross term
  localparam int unsigned LW  = PW / 2;           // low half of magnitude
  localparam int unsigned HW  = PW - LW;          // high half
  localparam int unsigned QW  = 2 * PW;           // square
  localparam int unsigned NST = 6;

  localparam int unsigned L = tun_pkg::LANES;

  logic [NST-1:0]       vld_q;
  logic [L-1:0]         neg3_q, neg4_q, neg5_q, neg6_q;
  logic                 degen_q;

  logic signed [EW-1:0] e_q [L];
  logic signed [EW-1:0] f_q [L];
  logic signed [PW-1:0] p_q [L];
  logic signed [PW-1:0] m_q [L];
  logic [PW-1:0]        mag_q [L];
  logic [2*HW-1:0]      hh_q [L];
  logic [HW+LW-1:0]     hl_q [L];
  logic [2*LW-1:0]      ll_q [L];
  logic [QW-1:0]        sq5_q [L];
  logic [SW-1:0]        sq6_q [L];
  logic [SW-1:0]        s_q;

  logic signed [CNW-1:0] cr   [L];
  logic [PW-1:0]         mag  [L];
  logic [L-1:0]          neg;
  logic [QW-1:0]         sqc  [L];
  logic [SW-1:0]         ssum;

  // cross terms and magnitudes
  always_comb begin
    for (int l = 0; l < L; l++) begin
      cr[l]  = CNW'(p_q[l]) - CNW'(m_q[l]);
      neg[l] = cr[l][CNW-1];
      mag[l] = neg[l] ? PW'(-cr[l]) : PW'(cr[l]);
    end
  end

  // recombine partial squares and add them up
  always_comb begin
    for (int l = 0; l < L; l++) begin
      sqc[l] = (QW'(hh_q[l]) << (2 * LW)) + (QW'(hl_q[l]) << (LW + 1)) + QW'(ll_q[l]);
    end
    ssum = SW'(sq5_q[0]) + SW'(sq5_q[1]) + SW'(sq5_q[2]);
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NST-2:0], valid_i};
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < L; l++) begin
        e_q[l] <= EW'(b_i[l]) - EW'(a_i[l]);
        f_q[l] <= EW'(c_i[l]) - EW'(a_i[l]);
      end
      // n = e x f
      p_q[0] <= PW'(e_q[1]) * PW'(f_q[2]);
      m_q[0] <= PW'(e_q[2]) * PW'(f_q[1]);
      p_q[1] <= PW'(e_q[2]) * PW'(f_q[0]);
      m_q[1] <= PW'(e_q[0]) * PW'(f_q[2]);
      p_q[2] <= PW'(e_q[0]) * PW'(f_q[1]);
      m_q[2] <= PW'(e_q[1]) * PW'(f_q[0]);
      for (int l = 0; l < L; l++) begin
        mag_q[l] <= mag[l];
        hh_q[l]  <= (2*HW)'(mag_q[l][PW-1:LW]) * (2*HW)'(mag_q[l][PW-1:LW]);
        hl_q[l]  <= (HW+LW)'(mag_q[l][PW-1:LW]) * (HW+LW)'(mag_q[l][LW-1:0]);
        ll_q[l]  <= (2*LW)'(mag_q[l][LW-1:0]) * (2*LW)'(mag_q[l][LW-1:0]);
        sq5_q[l] <= sqc[l];
        sq6_q[l] <= SW'(sq5_q[l]);
      end
      s_q     <= ssum;
      degen_q <= (ssum == '0);
      neg3_q  <= neg;
      neg4_q  <= neg3_q;
      neg5_q  <= neg4_q;
      neg6_q  <= neg5_q;
    end
  end

  assign ctl_o.valid = vld_q[NST-1];
  assign ctl_o.degen = degen_q;
  assign ctl_o.neg   = neg6_q;
  assign sq_o        = sq6_q;
  assign s_o         = s_q;

endmodule

FILE: design/tun_div_cell.sv
// ----------------------------------------------------------------------------
// tun_div_cell: one restoring division step for all three lanes
// Produces one quotient bit of c^2 * 4^(F+1) / s per lane and passes the
// partial remainder and the divisor to the next cell.
// ----------------------------------------------------------------------------
module tun_div_cell #(
  parameter int unsigned SW    = 74,
  parameter int unsigned UW    = 31,
  parameter bit          FIRST = 1'b0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [SW-1:0] rem_i [tun_pkg::LANES],
  input  logic [UW-1:0] u_i   [tun_pkg::LANES],
  input  logic [SW-1:0] s_i,
  output logic [SW-1:0] rem_o [tun_pkg::LANES],
  output logic [UW-1:0] u_o   [tun_pkg::LANES],
  output logic [SW-1:0] s_o
);

  localparam int unsigned L = tun_pkg::LANES;

  logic [SW:0]   t    [L];
  logic [SW:0]   diff [L];
  logic [L-1:0]  ge;
  logic [SW-1:0] rem_d [L];
  logic [UW-1:0] u_d   [L];

  // first cell compares without shifting
  always_comb begin
    for (int l = 0; l < L; l++) begin
      t[l]     = FIRST ? {1'b0, rem_i[l]} : {rem_i[l], 1'b0};
      diff[l]  = t[l] - {1'b0, s_i};
      ge[l]    = (t[l] >= {1'b0, s_i});
      rem_d[l] = ge[l] ? diff[l][SW-1:0] : t[l][SW-1:0];
      u_d[l]   = {u_i[l][UW-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= rem_d;
      u_o   <= u_d;
      s_o   <= s_i;
    end
  end

endmodule

FILE: design/tun_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tun_sqrt_cell: one digit-pair step of the integer square root
// Each cell tries one fixed power of four against the remaining value.
// ----------------------------------------------------------------------------
module tun_sqrt_cell #(
  parameter int unsigned RSW  = 32,
  parameter int unsigned NSQ  = 16,
  parameter int unsigned STEP = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [RSW-1:0] v_i [tun_pkg::LANES],
  input  logic [RSW-1:0] r_i [tun_pkg::LANES],
  output logic [RSW-1:0] v_o [tun_pkg::LANES],
  output logic [RSW-1:0] r_o [tun_pkg::LANES]
);

  localparam int unsigned      L    = tun_pkg::LANES;
  localparam int unsigned      SH   = 2 * (NSQ - 1 - STEP);
  localparam logic [RSW-1:0]   BITV = RSW'(1) << SH;

  logic [RSW:0]   trial [L];
  logic [L-1:0]   ge;
  logic [RSW-1:0] v_d   [L];
  logic [RSW-1:0] r_d   [L];

  always_comb begin
    for (int l = 0; l < L; l++) begin
      trial[l] = {1'b0, r_i[l]} + {1'b0, BITV};
      ge[l]    = ({1'b0, v_i[l]} >= trial[l]);
      v_d[l]   = ge[l] ? (v_i[l] - trial[l][RSW-1:0]) : v_i[l];
      r_d[l]   = ge[l] ? ((r_i[l] >> 1) + BITV) : (r_i[l] >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_o <= v_d;
      r_o <= r_d;
    end
  end

endmodule

FILE: design/triangle_unit_normal.sv
// ----------------------------------------------------------------------------
// triangle_unit_normal: unit face normal of one triangle per clock when ready
//
//   channel  dir  word
//   tri_i    in   vertices A, B, C (ax..cz), signed COORD_WIDTH bits each
//   nrm_o    out  nx, ny, nz signed Q2.14, degenerate flag
//
// One triangle is accepted every cycle while tri_i.ready is high; results
// leave in input order. The pipeline holds six front stages, one cell per
// quotient bit, one cell per root digit pair, and the output register.
// The whole pipeline advances together; a two-entry output register/skid
// lets one more word in while a result waits, then tri_i.ready drops.
// Reset clears all valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module triangle_unit_normal #(
  parameter int unsigned COORD_WIDTH      = 16,
  parameter int unsigned NORMAL_FRAC_BITS = 14
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tun_in_if.sink           tri_i,
  tun_out_if.source        nrm_o
);

  localparam int unsigned L     = tun_pkg::LANES;
  localparam int unsigned OW    = tun_pkg::OUT_W;
  localparam int unsigned PW    = 2 * (COORD_WIDTH + 1);
  localparam int unsigned SW    = 2 * PW + 2;
  localparam int unsigned UW    = 2 * NORMAL_FRAC_BITS + 3;
  localparam int unsigned NDIV  = UW;
  localparam int unsigned NSQ   = (UW + 1) / 2;
  localparam int unsigned RSW   = 2 * NSQ;
  localparam int unsigned DEPTH = NDIV + NSQ;

  logic en;

  logic signed [COORD_WIDTH-1:0] a_in [L];
  logic signed [COORD_WIDTH-1:0] b_in [L];
  logic signed [COORD_WIDTH-1:0] c_in [L];

  tun_pkg::ctl_t front_ctl;
  tun_pkg::ctl_t ctl_q [DEPTH];

  logic [SW-1:0]  rem_w [NDIV+1][L];
  logic [UW-1:0]  u_w   [NDIV+1][L];
  logic [SW-1:0]  s_w   [NDIV+1];
  logic [RSW-1:0] v_w   [NSQ+1][L];
  logic [RSW-1:0] r_w   [NSQ+1][L];

  logic [RSW:0]           rnd    [L];
  logic [OW-1:0]          qmag   [L];
  logic signed [OW-1:0]   res_n  [L];
  tun_pkg::ctl_t          last;

  logic                   out_valid_q, skid_valid_q;
  logic signed [OW-1:0]   out_n_q  [L];
  logic signed [OW-1:0]   skid_n_q [L];
  logic                   out_dg_q, skid_dg_q;
  logic                   push, take;

  // pipeline moves whenever the skid entry is free
  assign en          = !skid_valid_q;
  assign tri_i.ready = en;

  assign a_in = '{tri_i.ax, tri_i.ay, tri_i.az};
  assign b_in = '{tri_i.bx, tri_i.by_coord, tri_i.bz};
  assign c_in = '{tri_i.cx, tri_i.cy, tri_i.cz};

  tun_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .SW          (SW)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (tri_i.valid),
    .a_i     (a_in),
    .b_i     (b_in),
    .c_i     (c_in),
    .ctl_o   (front_ctl),
    .sq_o    (rem_w[0]),
    .s_o     (s_w[0])
  );

  // control word line alongside the cells
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DEPTH; k++) begin
        ctl_q[k] <= '0;
      end
    end else if (en) begin
      ctl_q[0] <= front_ctl;
      for (int k = 1; k < DEPTH; k++) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end
  end

  // division cells: one quotient bit each
  always_comb begin
    for (int l = 0; l < L; l++) begin
      u_w[0][l] = '0;
    end
  end

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    tun_div_cell #(
      .SW    (SW),
      .UW    (UW),
      .FIRST (k == 0)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (rem_w[k]),
      .u_i   (u_w[k]),
      .s_i   (s_w[k]),
      .rem_o (rem_w[k+1]),
      .u_o   (u_w[k+1]),
      .s_o   (s_w[k+1])
    );
  end

  // square root cells: one root bit each
  always_comb begin
    for (int l = 0; l < L; l++) begin
      v_w[0][l] = RSW'(u_w[NDIV][l]);
      r_w[0][l] = '0;
    end
  end

  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    tun_sqrt_cell #(
      .RSW  (RSW),
      .NSQ  (NSQ),
      .STEP (j)
    ) u_sqrt (
      .clk_i (clk_i),
      .en_i  (en),
      .v_i   (v_w[j]),
      .r_i   (r_w[j]),
      .v_o   (v_w[j+1]),
      .r_o   (r_w[j+1])
    );
  end

  // round half up, apply sign, force zero when degenerate
  assign last = ctl_q[DEPTH-1];
  always_comb begin
    for (int l = 0; l < L; l++) begin
      rnd[l]  = {1'b0, r_w[NSQ][l]} + (RSW+1)'(1);
      qmag[l] = rnd[l][OW:1];
      if (last.degen) begin
        res_n[l] = '0;
      end else if (last.neg[l]) begin
        res_n[l] = -$signed(qmag[l]);
      end else begin
        res_n[l] = $signed(qmag[l]);
      end
    end
  end

  // output register plus skid entry
  assign push = en && last.valid;
  assign take = out_valid_q && nrm_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (take) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push;
      end
    end else if (push) begin
      if (out_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && skid_valid_q) begin
      out_n_q  <= skid_n_q;
      out_dg_q <= skid_dg_q;
    end else if (push && (take || !out_valid_q)) begin
      out_n_q  <= res_n;
      out_dg_q <= last.degen;
    end
    if (push && !take && out_valid_q) begin
      skid_n_q  <= res_n;
      skid_dg_q <= last.degen;
    end
  end

  assign nrm_o.valid      = out_valid_q;
  assign nrm_o.nx         = out_n_q[0];
  assign nrm_o.ny         = out_n_q[1];
  assign nrm_o.nz         = out_n_q[2];
  assign nrm_o.degenerate = out_dg_q;

  // skid entry is only used behind a held output word
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word without output word");

  // full skid blocks the input side
  a_no_accept_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !tri_i.ready)
    else $error("input accepted with skid full");

  // degenerate results carry a zero normal
  a_degen_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nrm_o.valid && nrm_o.degenerate) |->
      (nrm_o.nx == '0 && nrm_o.ny == '0 && nrm_o.nz == '0))
    else $error("degenerate word with nonzero normal");

  // a delivered result from the pipe must find room
  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && out_valid_q && !take) |=> skid_valid_q)
    else $error("result dropped at output");

endmodule
